### sv/ima_adpcm_block_decoder_macros.svh
// Assertion helpers used by the checker file of the block decoder.
`ifndef IMA_ADPCM_BLOCK_DECODER_MACROS_SVH
`define IMA_ADPCM_BLOCK_DECODER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define IMADEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Same, but also checked while reset is applied.
`define IMADEC_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/imadec_pkg.sv
package imadec_pkg;

  typedef logic [14:0] step_t;
  typedef logic signed [4:0] idx_adj_t;

  // Position of the next header byte within a block
  typedef enum logic [1:0] {
    HDR_PRED_LO  = 2'd0,
    HDR_PRED_HI  = 2'd1,
    HDR_STEP     = 2'd2,
    HDR_RESERVED = 2'd3
  } hdr_pos_t;

  localparam logic [6:0] INDEX_MAX   = 7'd88;
  localparam logic [6:0] MAX_SAMPLES = 7'd64;

  localparam step_t STEP_TABLE [0:88] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
    15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
    15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
    15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
    15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
    15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
    15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  localparam idx_adj_t INDEX_ADJUST [0:15] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8,
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
  };

endpackage

### sv/ima_adpcm_block_decoder.sv
// Channel  Dir  Ports                         Transfer carries
// in       in   in_tvalid/in_tready           tdata: data_byte[7:0]; tuser: block_start
// out      out  out_tvalid/out_tready         tdata: sample[15:0]; tlast: last_of_block
// cfg      in   cfg_valid/cfg_ready           cfg_data: samples_per_block[6:0]
//
// A data byte yields one sample per nibble while the block has room left,
// and it is dropped when the block is already complete.
// Reset (rst_n low, synchronous) empties both registers, clears the decoder
// state and sets samples_per_block to 64. cfg_ready is always high.
// A stalled result holds the decode stage; the input is still taken whenever
// the held byte finishes in the same cycle.
module ima_adpcm_block_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] block_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  // Configuration
  logic [6:0] spb_r;
  logic [6:0] limit;

  // Input hold register
  logic       hold_valid_r, hold_valid_nxt;
  logic [7:0] hold_byte_r;
  logic       hold_start_r;
  logic       phase_r, phase_nxt;

  // Decoder state
  logic [15:0]          predictor_r, predictor_nxt;
  logic [6:0]           step_index_r, step_index_nxt;
  imadec_pkg::hdr_pos_t byte_pos_r, byte_pos_nxt, pos_eff, pos_succ;
  logic [6:0]           count_r, count_nxt, cnt_eff;
  logic                 hdr_done_r, hdr_done_nxt, hdone_eff;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_sample_r, out_sample_nxt;
  logic        out_last_r, out_last_nxt;

  logic        can_go, step_go, start_eff, consume, emit, in_xfer;
  logic [3:0]  nibble;
  logic [6:0]  idx;
  imadec_pkg::step_t step;
  logic [16:0] diff;
  logic signed [17:0] sum;
  logic [15:0] sample_sat;
  logic signed [7:0]  idx_sum;
  logic [6:0]  idx_new;
  logic [6:0]  cnt_inc;

  assign cfg_ready = 1'b1;

  always_comb begin
    priority if (spb_r == 7'd0) begin
      limit = 7'd1;
    end else if (spb_r > imadec_pkg::MAX_SAMPLES) begin
      limit = imadec_pkg::MAX_SAMPLES;
    end else begin
      limit = spb_r;
    end
  end

  assign can_go    = !out_valid_r || out_tready;
  assign step_go   = hold_valid_r && can_go;
  // block_start applies once, when the low nibble / header step runs
  assign start_eff = hold_start_r && !phase_r;
  assign pos_eff   = start_eff ? imadec_pkg::HDR_PRED_LO : byte_pos_r;
  assign cnt_eff   = start_eff ? 7'd0 : count_r;
  assign hdone_eff = start_eff ? 1'b0 : hdr_done_r;
  assign cnt_inc   = cnt_eff + 7'd1;

  // Header byte sequencing
  always_comb begin
    unique case (pos_eff)
      imadec_pkg::HDR_PRED_LO:  pos_succ = imadec_pkg::HDR_PRED_HI;
      imadec_pkg::HDR_PRED_HI:  pos_succ = imadec_pkg::HDR_STEP;
      imadec_pkg::HDR_STEP:     pos_succ = imadec_pkg::HDR_RESERVED;
      imadec_pkg::HDR_RESERVED: pos_succ = imadec_pkg::HDR_PRED_LO;
      default:                  pos_succ = imadec_pkg::HDR_PRED_LO;
    endcase
  end

  // Nibble decode: step lookup, difference, saturating add, index update
  assign nibble = phase_r ? hold_byte_r[7:4] : hold_byte_r[3:0];
  assign idx    = (step_index_r > imadec_pkg::INDEX_MAX) ? imadec_pkg::INDEX_MAX
                                                         : step_index_r;
  assign step   = imadec_pkg::STEP_TABLE[idx];

  always_comb begin
    diff = {5'd0, step[14:3]};
    if (nibble[2]) diff = diff + {2'd0, step};
    if (nibble[1]) diff = diff + {3'd0, step[14:1]};
    if (nibble[0]) diff = diff + {4'd0, step[14:2]};
  end

  always_comb begin
    if (nibble[3]) begin
      sum = {{2{predictor_r[15]}}, predictor_r} - $signed({1'b0, diff});
    end else begin
      sum = {{2{predictor_r[15]}}, predictor_r} + $signed({1'b0, diff});
    end
    priority if (sum > 18'sd32767) begin
      sample_sat = 16'h7fff;
    end else if (sum < -18'sd32768) begin
      sample_sat = 16'h8000;
    end else begin
      sample_sat = sum[15:0];
    end
  end

  always_comb begin
    idx_sum = $signed({1'b0, idx}) + 8'(imadec_pkg::INDEX_ADJUST[nibble]);
    priority if (idx_sum < 8'sd0) begin
      idx_new = 7'd0;
    end else if (idx_sum > $signed({1'b0, imadec_pkg::INDEX_MAX})) begin
      idx_new = imadec_pkg::INDEX_MAX;
    end else begin
      idx_new = idx_sum[6:0];
    end
  end

  // One step of the decode stage
  always_comb begin
    predictor_nxt  = predictor_r;
    step_index_nxt = step_index_r;
    byte_pos_nxt   = byte_pos_r;
    count_nxt      = count_r;
    hdr_done_nxt   = hdr_done_r;
    phase_nxt      = phase_r;
    consume        = 1'b0;
    emit           = 1'b0;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;

    if (step_go) begin
      count_nxt = cnt_eff;
      if (!hdone_eff) begin
        consume      = 1'b1;
        phase_nxt    = 1'b0;
        byte_pos_nxt = pos_succ;
        hdr_done_nxt = 1'b0;
        unique case (pos_eff)
          imadec_pkg::HDR_PRED_LO: begin
            predictor_nxt = {8'h00, hold_byte_r};
          end
          imadec_pkg::HDR_PRED_HI: begin
            predictor_nxt = {hold_byte_r, predictor_r[7:0]};
            if (cnt_eff < limit) begin
              emit           = 1'b1;
              out_sample_nxt = {hold_byte_r, predictor_r[7:0]};
            end
          end
          imadec_pkg::HDR_STEP: begin
            step_index_nxt = (hold_byte_r > {1'b0, imadec_pkg::INDEX_MAX})
                           ? imadec_pkg::INDEX_MAX : hold_byte_r[6:0];
          end
          imadec_pkg::HDR_RESERVED: begin
            hdr_done_nxt = 1'b1;
          end
          default: begin
            hdr_done_nxt = 1'b0;
          end
        endcase
      end else if (cnt_eff < limit) begin
        emit           = 1'b1;
        predictor_nxt  = sample_sat;
        step_index_nxt = idx_new;
        out_sample_nxt = sample_sat;
        // advance to the high nibble only while the block has room left
        if (!phase_r && (cnt_inc < limit)) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          consume   = 1'b1;
        end
      end else begin
        // block complete: drop the byte
        phase_nxt = 1'b0;
        consume   = 1'b1;
      end
      if (emit) begin
        count_nxt    = cnt_inc;
        out_last_nxt = (cnt_inc >= limit);
      end
    end
  end

  assign in_tready = !hold_valid_r || consume;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    if (in_xfer) begin
      hold_valid_nxt = 1'b1;
    end else if (consume) begin
      hold_valid_nxt = 1'b0;
    end else begin
      hold_valid_nxt = hold_valid_r;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r        <= 7'd64;
      hold_valid_r <= 1'b0;
      phase_r      <= 1'b0;
      predictor_r  <= 16'd0;
      step_index_r <= 7'd0;
      byte_pos_r   <= imadec_pkg::HDR_PRED_LO;
      count_r      <= 7'd0;
      hdr_done_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        spb_r <= cfg_data;
      end
      hold_valid_r <= hold_valid_nxt;
      phase_r      <= phase_nxt;
      predictor_r  <= predictor_nxt;
      step_index_r <= step_index_nxt;
      byte_pos_r   <= byte_pos_nxt;
      count_r      <= count_nxt;
      hdr_done_r   <= hdr_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_byte_r  <= in_tdata;
      hold_start_r <= in_tuser;
    end
    if (emit) begin
      out_sample_r <= out_sample_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_last_r;

endmodule

### sv/imadec_chk.sv
`include "ima_adpcm_block_decoder_macros.svh"

module imadec_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result holds its value
  `IMADEC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                      out_tvalid && $stable(out_tdata) && $stable(out_tlast),
                      "result changed while stalled")

  // Input backpressure only while a result is pending or the second nibble follows
  `IMADEC_ASSERT_NEXT(a_ready_low_has_result, !in_tready, out_tvalid,
                      "input stalled with no result pending")

  // Reset empties the result register
  `IMADEC_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind ima_adpcm_block_decoder imadec_chk u_imadec_chk (.*);

### sim/tb_ima_adpcm_block_decoder.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0] sample;
  logic        last;
} pcm_result_t;

// Tracks the decoder state alongside the block and holds the samples still owed by it.
class adpcm_scoreboard;
  logic [6:0]           spb_reg;
  logic [15:0]          predictor;
  logic [6:0]           step_idx;
  imadec_pkg::hdr_pos_t hdr_pos;
  logic [6:0]           emitted;
  bit                   hdr_done;
  pcm_result_t          owed_samples[$];
  int                   errors;

  function new();
    spb_reg   = imadec_pkg::MAX_SAMPLES;
    predictor = '0;
    step_idx  = '0;
    hdr_pos   = imadec_pkg::HDR_PRED_LO;
    emitted   = '0;
    hdr_done  = 1'b0;
    errors    = 0;
  endfunction

  function void set_spb(logic [6:0] v);
    spb_reg = v;
  endfunction

  // Effective sample count: zero acts as one, oversize acts as the maximum.
  function int unsigned limit();
    int unsigned n;
    n = 32'(spb_reg);
    if (n < 1) n = 1;
    if (n > imadec_pkg::MAX_SAMPLES) n = 32'(imadec_pkg::MAX_SAMPLES);
    return n;
  endfunction

  function int pending();
    return owed_samples.size();
  endfunction

  function void owe_sample();
    pcm_result_t r;
    emitted  = emitted + 7'd1;
    r.sample = predictor;
    r.last   = (emitted >= limit());
    owed_samples.push_back(r);
  endfunction

  function void decode_nibble(logic [3:0] nib);
    int unsigned ix;
    int step, diff, s, ni;
    ix   = 32'((step_idx > imadec_pkg::INDEX_MAX) ? imadec_pkg::INDEX_MAX : step_idx);
    step = int'(imadec_pkg::STEP_TABLE[ix]);
    diff = step >> 3;
    if (nib[2]) diff += step;
    if (nib[1]) diff += step >> 1;
    if (nib[0]) diff += step >> 2;
    if (nib[3]) diff = -diff;
    s = int'($signed(predictor)) + diff;
    if (s > 32767) s = 32767;
    else if (s < -32768) s = -32768;
    predictor = s[15:0];
    ni = int'(ix) + int'(imadec_pkg::INDEX_ADJUST[nib]);
    if (ni < 0) ni = 0;
    else if (ni > int'(imadec_pkg::INDEX_MAX)) ni = int'(imadec_pkg::INDEX_MAX);
    step_idx = ni[6:0];
  endfunction

  function void note_byte(logic [7:0] b, logic start);
    if (start) begin
      hdr_pos  = imadec_pkg::HDR_PRED_LO;
      emitted  = '0;
      hdr_done = 1'b0;
    end
    if (!hdr_done) begin
      case (hdr_pos)
        imadec_pkg::HDR_PRED_LO: predictor = {8'h00, b};
        imadec_pkg::HDR_PRED_HI: begin
          predictor = {b, predictor[7:0]};
          if (emitted < limit()) owe_sample();
        end
        imadec_pkg::HDR_STEP:
          step_idx = (b > imadec_pkg::INDEX_MAX) ? imadec_pkg::INDEX_MAX : b[6:0];
        imadec_pkg::HDR_RESERVED: hdr_done = 1'b1;
      endcase
      hdr_pos = imadec_pkg::hdr_pos_t'(hdr_pos + 2'd1);
    end else if (emitted < limit()) begin
      decode_nibble(b[3:0]);
      owe_sample();
      if (emitted < limit()) begin
        decode_nibble(b[7:4]);
        owe_sample();
      end
    end
  endfunction

  function void check_sample(logic [15:0] smp, logic last);
    pcm_result_t r;
    if (owed_samples.size() == 0) begin
      errors++;
      $display("%0t: unexpected sample, expected none, actual %0d last %0b",
               $time, $signed(smp), last);
      return;
    end
    r = owed_samples.pop_front();
    if (smp !== r.sample) begin
      errors++;
      $display("%0t: sample mismatch, expected %0d, actual %0d",
               $time, $signed(r.sample), $signed(smp));
    end
    if (last !== r.last) begin
      errors++;
      $display("%0t: last_of_block mismatch, expected %0b, actual %0b",
               $time, r.last, last);
    end
  endfunction
endclass

module tb_ima_adpcm_block_decoder;

  localparam int WATCHDOG_LIMIT = 5000;  // well above the long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 8;     // only the predictor high header byte gives a sample; let them drain
  localparam int RANDOM_ITEMS   = 2000;

  typedef enum logic [1:0] {
    RX_OPEN,     // always ready
    RX_COIN,     // ready half the time
    RX_QUARTER,  // ready one cycle in four
    RX_MOSTLY    // ready with probability seven eighths
  } rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] block_start
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] sample
  logic        out_tlast;  // last_of_block
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;   // [6:0] samples_per_block

  adpcm_scoreboard sb;
  int  bytes_sent;
  int  burst_left;
  int  idle_cycles;
  bit  hold_req;

  ima_adpcm_block_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Sample every handshake on the edge where it completes; inputs change only
  // through nonblocking updates, so these reads see the pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_spb(cfg_data);
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_sample(out_tdata, out_tlast);
    end
  end

  // Watchdog: count cycles without any transfer on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver: switch between stall patterns every so often; on request,
  // hold off for a long stretch so the block backs up into its input.
  initial begin
    rx_mode_t rx_mode;
    int       rx_left;
    int       rx_phase;
    rx_mode  = RX_OPEN;
    rx_left  = 0;
    rx_phase = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
          RX_OPEN:    out_tready <= 1'b1;
          RX_COIN:    out_tready <= 1'($urandom_range(0, 1));
          RX_QUARTER: out_tready <= (rx_phase % 4 == 0);
          RX_MOSTLY:  out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Offer one byte and hold it until it transfers. Bursts of random length
  // are separated by idle gaps of random length.
  task automatic send_byte(logic [7:0] b, logic start);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid and wait until every owed sample is out, then let any header
  // byte still in flight settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_spb(logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One block: four header bytes, then about enough data bytes to reach the
  // count, sometimes cut short, sometimes running past it.
  // mode 0: random data; 1: large nibbles of one sign (saturation);
  // 2: small nibbles (index driven to zero).
  task automatic send_block(logic marked, int mode);
    int         nbytes;
    int         r;
    logic       sgn;
    logic [7:0] b;
    send_byte(8'($urandom), marked);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 88) : $urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    nbytes = sb.limit() / 2;
    r = $urandom_range(0, 9);
    if (r == 0) nbytes = $urandom_range(0, nbytes);
    else if (r < 3) nbytes += $urandom_range(1, 3);
    sgn = 1'($urandom_range(0, 1));
    repeat (nbytes) begin
      case (mode)
        1:       b = {sgn, 3'($urandom_range(4, 7)), sgn, 3'($urandom_range(4, 7))};
        2:       b = {1'($urandom), 3'($urandom_range(0, 3)),
                      1'($urandom), 3'($urandom_range(0, 3))};
        default: b = 8'($urandom);
      endcase
      send_byte(b, 1'b0);
    end
  endtask

  initial begin
    int          phase;
    int          nblocks;
    int          pick;
    logic [6:0]  spb;
    sb         = new();
    bytes_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    hold_req   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Header without a mark right after reset: largest predictor, step
    // index above the table (clamps), then positive saturation.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC8, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h77, 1'b0);

    // Marked block: most negative predictor, negative saturation, sign-only
    // and zero nibbles.
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h58, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h88, 1'b0);
    send_byte(8'h00, 1'b0);

    // Lower the count below what this block already emitted: no more samples.
    wait_idle();
    write_spb(7'd3);
    send_byte(8'h11, 1'b0);

    // Count of three: the first data byte's nibble pair ends the block, the
    // byte after it is dropped.
    send_byte(8'h34, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b0);

    // Count register of zero acts as one: only the header sample, flagged last.
    wait_idle();
    write_spb(7'd0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'hFF, 1'b0);

    // Random phases: a new count each phase, mostly well-formed blocks.
    phase = 0;
    while (bytes_sent < RANDOM_ITEMS + 25) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      case (pick)
        0:       spb = 7'd1;
        1:       spb = 7'd64;
        2:       spb = 7'd0;
        3:       spb = 7'd127;
        4:       spb = 7'd2;
        5:       spb = 7'($urandom_range(65, 126));
        default: spb = 7'($urandom_range(1, 64));
      endcase
      if (phase == 4) spb = 7'd64;
      write_spb(spb);
      // Hold the receiver off while full-length blocks keep coming.
      if (phase == 4) hold_req = 1'b1;
      nblocks = (phase == 4) ? 4 : $urandom_range(1, 4);
      repeat (nblocks) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: short runs with a stray block start here and there
          repeat ($urandom_range(1, 6))
            send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
        send_block($urandom_range(0, 7) != 0, $urandom_range(0, 3) % 3);
      end
      phase++;
    end

    // Drain, then give the pipeline time to show any stray sample.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/imadec_pkg.sv
sv/ima_adpcm_block_decoder.sv
sv/imadec_chk.sv
sim/tb_ima_adpcm_block_decoder.sv
